// ===== rtl/gnct_pkg.sv =====
// Shared constants and types for the greedy nearest-city tour block.
// Used by gnct_ctrl, gnct_datapath and greedy_nearest_city_tour_top.
package gnct_pkg;

    // Default parameter values.
    localparam int MAX_CITIES_DEF = 64;
    localparam int DIST_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int CITY_W      = 6;
    localparam int ADDR_CITIES = 64;
    localparam int ADDR_W      = 2 * CITY_W;
    localparam int CFG_CNT_W   = 7;
    localparam int DIST_IN_W   = 16;
    localparam int PICK_W      = 16;
    localparam int COST_W      = 23;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COST_W-1:0] COST_MAX   = 23'h7F_FFFF;
    localparam logic [PICK_W-1:0] PICK_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CITY_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOUR_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_CITY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_CITY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_LIMIT  = 3'd4;

    // Input item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic mem_wr;
        logic run_start;
        logic link_issue;
        logic step_begin;
        logic scan_issue;
        logic step_end;
        logic final_emit;
        logic final_add;
        logic last_emit;
    } gnct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic steps_zero;
        logic link_last;
        logic scan_last;
        logic out_free;
    } gnct_status_t;

endpackage

// ===== rtl/gnct_ctrl.sv =====
// Controller state machine for the greedy nearest-city tour block.
// Depends on gnct_pkg for the command and status types.
module gnct_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_kind,
    output logic                   s_ready,
    input  gnct_pkg::gnct_status_t status,
    output gnct_pkg::gnct_cmd_t    cmd
);
    import gnct_pkg::*;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_LINK       = 4'd1;
    localparam logic [3:0] ST_LINK_DRAIN = 4'd2;
    localparam logic [3:0] ST_STEP       = 4'd3;
    localparam logic [3:0] ST_SCAN       = 4'd4;
    localparam logic [3:0] ST_SCAN_DRAIN = 4'd5;
    localparam logic [3:0] ST_STEP_END   = 4'd6;
    localparam logic [3:0] ST_FINAL      = 4'd7;
    localparam logic [3:0] ST_FINAL_ADD  = 4'd8;
    localparam logic [3:0] ST_LAST       = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_kind == KIND_WRITE)) begin
                    cmd.mem_wr = 1'b1;
                end else if (accept) begin
                    cmd.run_start = 1'b1;
                    state_next    = status.n_zero ? ST_STEP : ST_LINK;
                end
            end
            ST_LINK: begin
                cmd.link_issue = 1'b1;
                if (status.link_last) begin
                    state_next = ST_LINK_DRAIN;
                end
            end
            ST_LINK_DRAIN: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (status.steps_zero) begin
                    state_next = ST_FINAL;
                end else if (status.out_free) begin
                    cmd.step_begin = 1'b1;
                    state_next     = status.n_zero ? ST_STEP_END : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN: begin
                state_next = ST_STEP_END;
            end
            ST_STEP_END: begin
                cmd.step_end = 1'b1;
                state_next   = ST_STEP;
            end
            ST_FINAL: begin
                if (status.out_free) begin
                    cmd.final_emit = 1'b1;
                    state_next     = ST_FINAL_ADD;
                end
            end
            ST_FINAL_ADD: begin
                cmd.final_add = 1'b1;
                state_next    = ST_LAST;
            end
            ST_LAST: begin
                if (status.out_free) begin
                    cmd.last_emit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/gnct_datapath.sv =====
// Datapath for the greedy nearest-city tour: matrix memory, scan counters,
// visited and link flags, best-pick logic, cost adder and result register.
// Depends on gnct_pkg for widths, constants and the command/status types.
module gnct_datapath #(
    parameter int MAX_CITIES = gnct_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = gnct_pkg::DIST_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [gnct_pkg::CFG_CNT_W-1:0]      city_count,
    input  logic [gnct_pkg::CFG_CNT_W-1:0]      tour_length,
    input  logic [gnct_pkg::CITY_W-1:0]         start_city,
    input  logic [gnct_pkg::CITY_W-1:0]         end_city,
    input  logic [gnct_pkg::PICK_W-1:0]         pick_limit,
    input  logic [gnct_pkg::CITY_W-1:0]         s_row,
    input  logic [gnct_pkg::CITY_W-1:0]         s_col,
    input  logic [gnct_pkg::DIST_IN_W-1:0]      s_distance,
    input  gnct_pkg::gnct_cmd_t                 cmd,
    output gnct_pkg::gnct_status_t              status,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gnct_pkg::CITY_W-1:0]         m_city,
    output logic [gnct_pkg::COST_W-1:0]         m_total_cost,
    output logic                                m_last,
    output logic                                m_stuck
);
    import gnct_pkg::*;

    localparam int IDX_W = $clog2(MAX_CITIES);
    localparam int CNT_W = $clog2(MAX_CITIES + 1);
    localparam int CMP_W = (DIST_BITS > PICK_W) ? DIST_BITS : PICK_W;
    localparam int SUM_W = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;

    // Matrix memory and its registered read port.
    logic [DIST_BITS-1:0] mem [0:ADDR_CITIES*ADDR_CITIES-1];
    logic [DIST_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 rd_en;
    logic [31:0]          dist_ext;
    logic [DIST_BITS-1:0] wr_data;

    // Scan state.
    logic [IDX_W-1:0]      row_reg;
    logic [IDX_W-1:0]      col_reg;
    logic [CNT_W-1:0]      steps_left_reg;
    logic [CITY_W-1:0]     cur_reg;
    logic [CITY_W-1:0]     next_reg;
    logic [PICK_W-1:0]     best_reg;
    logic                  found_reg;
    logic [COST_W-1:0]     cost_reg;
    logic                  stuck_reg;
    logic [MAX_CITIES-1:0] visited_reg;
    logic [MAX_CITIES-1:0] link_reg;
    logic                  rd_valid_reg;
    logic                  rd_scan_reg;
    logic [IDX_W-1:0]      rd_idx_reg;

    // Result register.
    logic                  m_valid_reg;
    logic [CITY_W-1:0]     m_city_reg;
    logic [COST_W-1:0]     m_cost_reg;
    logic                  m_last_reg;
    logic                  m_stuck_reg;

    logic [CNT_W-1:0]      n_sat;
    logic [CNT_W-1:0]      len_sat;
    logic [CNT_W-1:0]      n_last;
    logic [CNT_W-1:0]      steps_init;
    logic                  col_last;
    logic                  emit;
    logic                  out_free;
    logic [CITY_W-1:0]     cand_city;
    logic                  qualify;
    logic [SUM_W-1:0]      add_op;
    logic [SUM_W-1:0]      sum;
    logic [COST_W-1:0]     cost_next;
    logic                  cur_in_range;

    // Counts saturate at the supported number of cities.
    assign n_sat   = (city_count > CFG_CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES)
                                                           : city_count[CNT_W-1:0];
    assign len_sat = (tour_length > CFG_CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES)
                                                            : tour_length[CNT_W-1:0];
    assign steps_init = (len_sat >= CNT_W'(2)) ? (len_sat - CNT_W'(2)) : '0;
    assign n_last     = n_sat - CNT_W'(1);
    assign col_last   = (CNT_W'(col_reg) == n_last);

    // Status back to the controller.
    assign out_free          = !m_valid_reg || m_ready;
    assign status.n_zero     = (n_sat == '0);
    assign status.steps_zero = (steps_left_reg == '0);
    assign status.link_last  = (CNT_W'(row_reg) == n_last) && col_last;
    assign status.scan_last  = col_last;
    assign status.out_free   = out_free;

    // Write data is fitted to the stored distance width.
    assign dist_ext = 32'(s_distance);
    assign wr_data  = dist_ext[DIST_BITS-1:0];

    // Read address: link pre-pass, candidate scan, or the final leg.
    assign rd_en = cmd.link_issue || cmd.scan_issue || cmd.final_emit;
    always_comb begin
        if (cmd.link_issue) begin
            rd_addr = {CITY_W'(row_reg), CITY_W'(col_reg)};
        end else if (cmd.scan_issue) begin
            rd_addr = {cur_reg, CITY_W'(col_reg)};
        end else begin
            rd_addr = {cur_reg, end_city};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[{s_row, s_col}] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // A candidate qualifies when its distance does not exceed the best so far.
    assign cand_city = CITY_W'(rd_idx_reg);
    assign qualify   = rd_valid_reg && rd_scan_reg && !visited_reg[rd_idx_reg]
                       && (cand_city != cur_reg) && (cand_city != end_city)
                       && (CMP_W'(rd_data_reg) <= CMP_W'(best_reg))
                       && link_reg[rd_idx_reg];

    // Saturating cost adder, shared by the step legs and the final leg.
    assign add_op    = cmd.final_add ? SUM_W'(rd_data_reg) : SUM_W'(best_reg);
    assign sum       = SUM_W'(cost_reg) + add_op;
    assign cost_next = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];

    assign cur_in_range = ({1'b0, cur_reg} < (CITY_W + 1)'(MAX_CITIES));
    assign emit         = cmd.step_begin || cmd.final_emit || cmd.last_emit;

    // Control flags and read pipeline valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg  <= '0;
            link_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.link_issue || cmd.scan_issue;
            if (cmd.run_start) begin
                visited_reg <= '0;
                link_reg    <= '0;
            end else begin
                if (cmd.step_begin && cur_in_range) begin
                    visited_reg[cur_reg[IDX_W-1:0]] <= 1'b1;
                end
                if (rd_valid_reg && !rd_scan_reg && (rd_data_reg != '0)) begin
                    link_reg[rd_idx_reg] <= 1'b1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Counters, walk state and result payload.
    always_ff @(posedge aclk) begin
        rd_scan_reg <= cmd.scan_issue;
        rd_idx_reg  <= cmd.link_issue ? row_reg : col_reg;

        if (cmd.run_start) begin
            row_reg        <= '0;
            col_reg        <= '0;
            steps_left_reg <= steps_init;
            cur_reg        <= start_city;
            cost_reg       <= '0;
            stuck_reg      <= 1'b0;
        end else if (cmd.link_issue) begin
            if (col_last) begin
                col_reg <= '0;
                row_reg <= row_reg + IDX_W'(1);
            end else begin
                col_reg <= col_reg + IDX_W'(1);
            end
        end else if (cmd.scan_issue) begin
            col_reg <= col_reg + IDX_W'(1);
        end else if (cmd.step_begin) begin
            col_reg <= '0;
        end

        if (cmd.step_begin) begin
            best_reg  <= pick_limit;
            next_reg  <= cur_reg;
            found_reg <= 1'b0;
        end else if (qualify) begin
            best_reg  <= PICK_W'(CMP_W'(rd_data_reg));
            next_reg  <= cand_city;
            found_reg <= 1'b1;
        end

        if (cmd.step_end) begin
            cost_reg       <= cost_next;
            stuck_reg      <= stuck_reg || !found_reg;
            cur_reg        <= next_reg;
            steps_left_reg <= steps_left_reg - CNT_W'(1);
        end else if (cmd.final_add) begin
            cost_reg <= cost_next;
        end

        if (emit) begin
            m_city_reg  <= cmd.last_emit ? end_city : cur_reg;
            m_cost_reg  <= cost_reg;
            m_last_reg  <= cmd.last_emit;
            m_stuck_reg <= stuck_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_city       = m_city_reg;
    assign m_total_cost = m_cost_reg;
    assign m_last       = m_last_reg;
    assign m_stuck      = m_stuck_reg;

endmodule

// ===== rtl/greedy_nearest_city_tour_top.sv =====
// Top level of the greedy nearest-city tour block: configuration registers,
// controller and datapath. Depends on gnct_pkg, gnct_ctrl and gnct_datapath.
//
// A write item stores one distance-matrix entry. In a run item, with n the
// saturated city_count and S the number of greedy steps (tour_length minus
// two), a pre-pass reads every row of the n-by-n matrix to find rows with a
// link, then each of the S steps reads one row of candidates. All reads go
// through the single read port of the matrix memory, one entry per cycle;
// each step and each closing result waits while the result register is
// still held by the downstream side. Results of a run leave through a
// one-entry output register, and a new item is accepted as soon as the last
// result of the previous run is loaded there.
module greedy_nearest_city_tour_top #(
    parameter int MAX_CITIES = gnct_pkg::MAX_CITIES_DEF,
    parameter int DIST_BITS  = gnct_pkg::DIST_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [gnct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gnct_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_kind,
    input  logic [gnct_pkg::CITY_W-1:0]      s_row,
    input  logic [gnct_pkg::CITY_W-1:0]      s_col,
    input  logic [gnct_pkg::DIST_IN_W-1:0]   s_distance,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gnct_pkg::CITY_W-1:0]      m_city,
    output logic [gnct_pkg::COST_W-1:0]      m_total_cost,
    output logic                             m_last,
    output logic                             m_stuck
);
    import gnct_pkg::*;

    logic [CFG_CNT_W-1:0] city_count_reg;
    logic [CFG_CNT_W-1:0] tour_length_reg;
    logic [CITY_W-1:0]    start_city_reg;
    logic [CITY_W-1:0]    end_city_reg;
    logic [PICK_W-1:0]    pick_limit_reg;

    gnct_cmd_t    cmd;
    gnct_status_t status;

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg  <= '0;
            tour_length_reg <= '0;
            start_city_reg  <= '0;
            end_city_reg    <= '0;
            pick_limit_reg  <= PICK_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CITY_COUNT:  city_count_reg  <= cfg_data[CFG_CNT_W-1:0];
                REG_TOUR_LENGTH: tour_length_reg <= cfg_data[CFG_CNT_W-1:0];
                REG_START_CITY:  start_city_reg  <= cfg_data[CITY_W-1:0];
                REG_END_CITY:    end_city_reg    <= cfg_data[CITY_W-1:0];
                REG_PICK_LIMIT:  pick_limit_reg  <= cfg_data[PICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gnct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gnct_datapath #(
        .MAX_CITIES (MAX_CITIES),
        .DIST_BITS  (DIST_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .city_count   (city_count_reg),
        .tour_length  (tour_length_reg),
        .start_city   (start_city_reg),
        .end_city     (end_city_reg),
        .pick_limit   (pick_limit_reg),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_distance   (s_distance),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_city       (m_city),
        .m_total_cost (m_total_cost),
        .m_last       (m_last),
        .m_stuck      (m_stuck)
    );

    // A result is loaded only when the output register is free or draining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step_begin || cmd.final_emit || cmd.last_emit) |-> (!m_valid || m_ready))
        else $error("result loaded over a pending result");

    // Loading the closing result returns the block to accepting items.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.last_emit |=> s_ready)
        else $error("input not ready after the closing result");

    // Once a run starts, no further item is taken until it completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.run_start |=> !s_ready)
        else $error("input accepted while a run is in progress");

    // Matrix reads for scanning never coincide with accepting input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !(cmd.link_issue || cmd.scan_issue))
        else $error("matrix scan while idle");

endmodule

// ===== tb/gnct_tour_checker.sv =====
// Checker for the greedy nearest-city tour block: watches the config port and both channels,
// predicts the tour of every run item and compares each result transfer with it.
// Depends on gnct_pkg for field widths, register indexes and item kinds.
module gnct_tour_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gnct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gnct_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_kind,
    input  logic [gnct_pkg::CITY_W-1:0]     s_row,
    input  logic [gnct_pkg::CITY_W-1:0]     s_col,
    input  logic [gnct_pkg::DIST_IN_W-1:0]  s_distance,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [gnct_pkg::CITY_W-1:0]     m_city,
    input  logic [gnct_pkg::COST_W-1:0]     m_total_cost,
    input  logic                            m_last,
    input  logic                            m_stuck,
    output int unsigned                     mismatch_count,
    output int unsigned                     pending_hops
);
    timeunit 1ns;
    timeprecision 1ps;
    import gnct_pkg::*;

    typedef struct packed {
        logic [CITY_W-1:0] city;
        logic [COST_W-1:0] cost;
        logic              last;
        logic              stuck;
    } tour_hop_t;

    // Shadow of the block's registers and distance store.
    logic [CFG_CNT_W-1:0] city_count_q;
    logic [CFG_CNT_W-1:0] tour_length_q;
    logic [CITY_W-1:0]    start_city_q;
    logic [CITY_W-1:0]    end_city_q;
    logic [PICK_W-1:0]    pick_limit_q;
    logic [DIST_IN_W-1:0] dist_mat [ADDR_CITIES][ADDR_CITIES];

    tour_hop_t   awaited_hops [$];
    int unsigned fail_tally = 0;

    function automatic tour_hop_t make_hop(input logic [CITY_W-1:0] city,
                                           input int unsigned cost,
                                           input logic last, input logic stuck);
        tour_hop_t hop;
        hop.city = city;
        hop.cost = cost[COST_W-1:0];
        hop.last = last;
        hop.stuck = stuck;
        return hop;
    endfunction

    // Walk the greedy tour over the shadow matrix and queue every city it emits.
    task automatic predict_tour_hops();
        int unsigned       scan_n;
        int unsigned       span;
        int unsigned       steps;
        int unsigned       tally;
        logic [CITY_W-1:0] here;
        logic [CITY_W-1:0] nxt;
        logic [PICK_W-1:0] best;
        bit                found;
        bit                stuck;
        bit                linked [ADDR_CITIES];
        bit                seen [ADDR_CITIES];

        scan_n = (city_count_q > MAX_CITIES_DEF) ? MAX_CITIES_DEF : city_count_q;
        span = (tour_length_q > MAX_CITIES_DEF) ? MAX_CITIES_DEF : tour_length_q;
        steps = (span >= 2) ? span - 2 : 0;

        // A city can only be picked if its own row has some link.
        for (int i = 0; i < ADDR_CITIES; i++) begin
            linked[i] = 1'b0;
            seen[i] = 1'b0;
            if (i < scan_n) begin
                for (int j = 0; j < scan_n; j++) begin
                    if (dist_mat[i][j] != '0) linked[i] = 1'b1;
                end
            end
        end

        here = start_city_q;
        tally = 0;
        stuck = 1'b0;
        for (int s = 0; s < steps; s++) begin
            seen[here] = 1'b1;
            awaited_hops.push_back(make_hop(here, tally, 1'b0, stuck));
            best = pick_limit_q;
            nxt = here;
            found = 1'b0;
            // Ties go to the highest index, so later candidates win on equal distance.
            for (int i = 0; i < scan_n; i++) begin
                if (!seen[i] && i != here && i != end_city_q &&
                    dist_mat[here][i] <= best && linked[i]) begin
                    best = dist_mat[here][i];
                    nxt = CITY_W'(i);
                    found = 1'b1;
                end
            end
            tally = tally + best;
            if (tally > COST_MAX) tally = COST_MAX;
            if (!found) stuck = 1'b1;
            here = nxt;
        end

        awaited_hops.push_back(make_hop(here, tally, 1'b0, stuck));
        tally = tally + dist_mat[here][end_city_q];
        if (tally > COST_MAX) tally = COST_MAX;
        awaited_hops.push_back(make_hop(end_city_q, tally, 1'b1, stuck));
    endtask

    // Everything is sampled at the rising edge, before the block's outputs move.
    always @(posedge aclk) begin
        tour_hop_t want;

        if (!aresetn) begin
            city_count_q <= '0;
            tour_length_q <= '0;
            start_city_q <= '0;
            end_city_q <= '0;
            pick_limit_q <= PICK_RESET;
            awaited_hops.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CITY_COUNT:  city_count_q <= cfg_data[CFG_CNT_W-1:0];
                    REG_TOUR_LENGTH: tour_length_q <= cfg_data[CFG_CNT_W-1:0];
                    REG_START_CITY:  start_city_q <= cfg_data[CITY_W-1:0];
                    REG_END_CITY:    end_city_q <= cfg_data[CITY_W-1:0];
                    REG_PICK_LIMIT:  pick_limit_q <= cfg_data[PICK_W-1:0];
                    default: ;
                endcase
            end

            // Result transfer: compare with the oldest expected hop.
            if (m_valid && m_ready) begin
                if (awaited_hops.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= 10)
                        $display("unexpected hop: city %0d cost %0d last %0b stuck %0b",
                                 m_city, m_total_cost, m_last, m_stuck);
                end else begin
                    want = awaited_hops.pop_front();
                    if (want.city !== m_city || want.cost !== m_total_cost ||
                        want.last !== m_last || want.stuck !== m_stuck) begin
                        fail_tally++;
                        if (fail_tally <= 10)
                            $display({"hop mismatch: exp city %0d cost %0d last %0b stuck %0b,",
                                      " got city %0d cost %0d last %0b stuck %0b"},
                                     want.city, want.cost, want.last, want.stuck,
                                     m_city, m_total_cost, m_last, m_stuck);
                    end
                end
            end

            // Input transfer: a write updates the matrix, a run queues its tour.
            if (s_valid && s_ready) begin
                if (s_kind == KIND_WRITE)
                    dist_mat[s_row][s_col] = s_distance;
                else
                    predict_tour_hops();
            end
        end
        mismatch_count <= fail_tally;
        pending_hops <= awaited_hops.size();
    end

endmodule

// ===== tb/tb_greedy_nearest_city_tour_top.sv =====
// Testbench top for greedy_nearest_city_tour_top: clock, reset, stimulus and the verdict.
// Checking is done by gnct_tour_checker; depends on gnct_pkg and the block's RTL.
module tb_greedy_nearest_city_tour_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gnct_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES  = 500;
    localparam int unsigned QUIET_LIMIT  = 40000;
    localparam int unsigned ITEM_TARGET  = 140;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_kind = KIND_WRITE;
    logic [CITY_W-1:0]     s_row = '0;
    logic [CITY_W-1:0]     s_col = '0;
    logic [DIST_IN_W-1:0]  s_distance = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CITY_W-1:0]     m_city;
    logic [COST_W-1:0]     m_total_cost;
    logic                  m_last;
    logic                  m_stuck;

    int unsigned mismatch_count;
    int unsigned pending_hops;

    // Stimulus-side view of the configuration and of which entries hold data.
    int unsigned scan_n = 0;
    int unsigned tour_start = 0;
    int unsigned tour_end = 0;
    bit          entry_loaded [ADDR_CITIES][ADDR_CITIES];

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned rx_wait = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_items = 0;

    greedy_nearest_city_tour_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_distance   (s_distance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_city       (m_city),
        .m_total_cost (m_total_cost),
        .m_last       (m_last),
        .m_stuck      (m_stuck)
    );

    gnct_tour_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_row          (s_row),
        .s_col          (s_col),
        .s_distance     (s_distance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_city         (m_city),
        .m_total_cost   (m_total_cost),
        .m_last         (m_last),
        .m_stuck        (m_stuck),
        .mismatch_count (mismatch_count),
        .pending_hops   (pending_hops)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Distances lean small so tours are well formed, with ties, gaps and huge values.
    function automatic logic [DIST_IN_W-1:0] rand_dist();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) return DIST_IN_W'($urandom_range(1, 4));
        if (roll < 65) return DIST_IN_W'($urandom_range(1, 300));
        if (roll < 75) return '0;
        if (roll < 82) return '1;
        return DIST_IN_W'($urandom_range(0, 65535));
    endfunction

    // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rx_wait = HOLD_CYCLES;
        end else if (rx_wait == 0 && rx_idle_on && $urandom_range(99) < 30) begin
            rx_wait = 1 + pick_gap();
        end
        if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer or register write ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one item and return at the edge of its transfer, with valid still high.
    task automatic push_item(input logic kind, input logic [CITY_W-1:0] r,
                             input logic [CITY_W-1:0] c, input logic [DIST_IN_W-1:0] d);
        int unsigned gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_row <= r;
        s_col <= c;
        s_distance <= d;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    task automatic write_entry(input int unsigned r, input int unsigned c,
                               input logic [DIST_IN_W-1:0] d);
        push_item(KIND_WRITE, CITY_W'(r), CITY_W'(c), d);
        entry_loaded[r][c] = 1'b1;
    endtask

    // Removing a city means zeroing its row within the scanned range.
    task automatic cut_city(input int unsigned r);
        for (int c = 0; c < scan_n; c++) write_entry(r, c, '0);
    endtask

    // Load every entry the next run can read that has never been written.
    task automatic load_missing_entries();
        for (int r = 0; r < ADDR_CITIES; r++) begin
            for (int c = 0; c < ADDR_CITIES; c++) begin
                if (!entry_loaded[r][c] && (r < scan_n || r == tour_start) &&
                    (c < scan_n || c == tour_end))
                    write_entry(r, c, rand_dist());
            end
        end
    endtask

    task automatic run_tour();
        load_missing_entries();
        push_item(KIND_RUN, CITY_W'($urandom), CITY_W'($urandom), DIST_IN_W'($urandom));
    endtask

    // Wait until every expected hop has been seen and the block has settled.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hops != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        @(posedge aclk);
    endtask

    task automatic apply_config(input int unsigned cc, input int unsigned tl,
                                input int unsigned sc, input int unsigned ec,
                                input int unsigned pl);
        wait_idle();
        cfg_write(REG_CITY_COUNT, cc);
        cfg_write(REG_TOUR_LENGTH, tl);
        cfg_write(REG_START_CITY, sc);
        cfg_write(REG_END_CITY, ec);
        cfg_write(REG_PICK_LIMIT, pl);
        cfg_wr_en <= 1'b0;
        scan_n = (cc > MAX_CITIES_DEF) ? MAX_CITIES_DEF : cc;
        tour_start = sc;
        tour_end = ec;
    endtask

    initial begin
        int unsigned cc;
        int unsigned tl;
        int unsigned sc;
        int unsigned ec;
        int unsigned pl;
        int unsigned roll;
        int unsigned burst;
        int unsigned phase;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, then a run under the reset settings (short tour).
        write_entry(0, 0, '0);
        write_entry(63, 63, '1);
        run_tour();

        // Ordinary tour with a tie from city 1 to cities 0 and 2.
        apply_config(5, 7, 1, 4, PICK_RESET);
        write_entry(1, 0, 7);
        write_entry(1, 2, 7);
        run_tour();

        // City 3 has no links left, so it can never be picked.
        cut_city(3);
        run_tour();

        // Nothing qualifies under a zero limit unless a zero distance links.
        apply_config(5, 7, 1, 4, 0);
        run_tour();

        // Tour length below two makes no steps; start and end coincide.
        apply_config(5, 1, 2, 2, 65535);
        run_tour();

        // Start and end outside the scanned range.
        apply_config(5, 6, 40, 63, 500);
        run_tour();

        // Tour lengths at and above the city limit: the walk runs out of cities and sticks.
        apply_config(5, 127, 0, 4, PICK_RESET);
        run_tour();
        apply_config(5, 64, 4, 0, 65535);
        run_tour();

        // Random phases: small tours mostly, with writes and deletions between runs.
        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            roll = $urandom_range(99);
            if (phase == 0 || roll < 85) cc = $urandom_range(3, 8);
            else if (roll < 95) cc = $urandom_range(0, 2);
            else cc = $urandom_range(9, 10);

            roll = $urandom_range(99);
            if (roll < 85) tl = $urandom_range(0, cc + 3);
            else if (roll < 93) tl = 127;
            else tl = 64;

            if (cc > 0 && $urandom_range(99) < 80) sc = $urandom_range(0, cc - 1);
            else sc = $urandom_range(0, 63);
            if (cc > 0 && $urandom_range(99) < 80) ec = $urandom_range(0, cc - 1);
            else ec = $urandom_range(0, 63);

            roll = $urandom_range(99);
            if (roll < 40) pl = PICK_RESET;
            else if (roll < 60) pl = $urandom_range(0, 300);
            else if (roll < 80) pl = 65535;
            else pl = $urandom_range(0, 65535);

            apply_config(cc, tl, sc, ec, pl);
            roll = $urandom_range(3);
            tx_idle_on = roll[0];
            rx_idle_on = roll[1];

            if (phase == 0) begin
                // Hold results back while runs keep coming, so the input stalls.
                tx_idle_on = 1'b0;
                hold_requests++;
                repeat (6) run_tour();
            end else begin
                burst = $urandom_range(3, 10);
                repeat (burst) begin
                    roll = $urandom_range(99);
                    if (roll < 45) begin
                        run_tour();
                    end else if (roll < 85 && scan_n > 0) begin
                        write_entry($urandom_range(0, scan_n - 1),
                                    ($urandom_range(3) == 0) ? tour_end
                                                             : $urandom_range(0, scan_n - 1),
                                    rand_dist());
                    end else if (roll < 90 && scan_n > 0) begin
                        cut_city($urandom_range(0, scan_n - 1));
                    end else begin
                        write_entry($urandom_range(0, 63), $urandom_range(0, 63),
                                    DIST_IN_W'($urandom));
                    end
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && pending_hops == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gnct_pkg.sv
rtl/gnct_ctrl.sv
rtl/gnct_datapath.sv
rtl/greedy_nearest_city_tour_top.sv
tb/gnct_tour_checker.sv
tb/tb_greedy_nearest_city_tour_top.sv
